>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property is checked at every rising edge of clk outside reset.
`define SLFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The property is checked at every rising edge of clk, reset included.
`define SLFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/slfp_pkg.sv
// ----------------------------------------------------------------------------
// slfp_pkg
// Types, constants and helper functions of the sensor line field parser.
// ----------------------------------------------------------------------------
package slfp_pkg;

  localparam int MAX_LINE = 127;
  localparam int LEN_W    = 7;
  localparam int MAG_W    = 23;
  localparam int VAL_W    = 24;
  localparam int SLOTS    = 4;
  localparam int ACC_W    = MAG_W + 4;

  localparam logic [LEN_W-1:0] LINE_FULL = LEN_W'(MAX_LINE);
  localparam logic [MAG_W-1:0] MAG_MAX   = {MAG_W{1'b1}};

  localparam int SLOT_O2 = 0;
  localparam int SLOT_F  = 1;
  localparam int SLOT_P  = 2;
  localparam int SLOT_T  = 3;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BLANK,
    PH_SIGN,
    PH_INT,
    PH_FRAC,
    PH_DONE
  } phase_t;

  // Adds a digit weight to the magnitude, scaling it by ten first when asked,
  // and saturates at the largest magnitude.
  function automatic logic [MAG_W-1:0] sat_step(input logic [MAG_W-1:0] mag,
                                                input logic scale10,
                                                input logic [9:0] addend);
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] sum;
    begin
      if (scale10) begin
        base = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
      end else begin
        base = {4'b0000, mag};
      end
      sum = base + {{(ACC_W-10){1'b0}}, addend};
      if (sum > {4'b0000, MAG_MAX}) begin
        sat_step = MAG_MAX;
      end else begin
        sat_step = sum[MAG_W-1:0];
      end
    end
  endfunction

  function automatic logic [VAL_W-1:0] to_signed(input logic [MAG_W-1:0] mag,
                                                 input logic neg);
    logic [VAL_W-1:0] ext;
    begin
      ext = {{(VAL_W-MAG_W){1'b0}}, mag};
      to_signed = neg ? (VAL_W'(0) - ext) : ext;
    end
  endfunction

endpackage

>>> src/sensor_line_field_parser.sv
// ----------------------------------------------------------------------------
// sensor_line_field_parser
// Splits received serial bytes into lines and reads the O2, flow and
// temperature readings of each line in hundredths.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Payload
//   --------+-----+----------------------------------------------------------
//   in_     | in  | tdata[7:0] rx_byte
//   out_    | out | tdata oxygen, flow, temperature (24 b each); tuser parse_ok
//
// One byte is taken per cycle unless the input stalls; each byte is registered
// in the input register and then folded into the line state, and a newline
// loads the result register from there.
// The result register decouples the sides: only a newline that ends a non-empty
// line and finds the previous result still untaken stalls the input.
// Synchronous active-low reset clears the line state and both valid flags.
// ----------------------------------------------------------------------------
module sensor_line_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [23:0] oxygen, [47:24] flow, [71:48] temperature
  output logic        out_tuser   // [0] parse_ok
);

  localparam int VW = slfp_pkg::VAL_W;
  localparam int MW = slfp_pkg::MAG_W;
  localparam int LW = slfp_pkg::LEN_W;
  localparam int NS = slfp_pkg::SLOTS;

  logic                s1_vld_r, s1_vld_nxt;
  logic [7:0]          s1_byte_r;
  logic [LW-1:0]       len_r, len_nxt;
  logic [15:0]         prev_r, prev_nxt;
  logic [NS-1:0]       seen_r, seen_nxt;
  slfp_pkg::phase_t    phase_r [NS];
  slfp_pkg::phase_t    phase_nxt [NS];
  logic [NS-1:0]       neg_r, neg_nxt;
  logic [MW-1:0]       mag_r [NS];
  logic [MW-1:0]       mag_nxt [NS];
  logic [1:0]          frac_r [NS];
  logic [1:0]          frac_nxt [NS];
  logic                out_vld_r, out_vld_nxt;
  logic [3*VW-1:0]     out_data_r, out_data_nxt;
  logic                out_ok_r, out_ok_nxt;

  logic                produce;
  logic                out_free;
  logic                s1_fire;
  logic [7:0]          c;
  logic                is_digit;
  logic                is_blank;
  logic [3:0]          dig;
  logic                ok;
  logic                flow_f;

  assign c        = s1_byte_r;
  assign is_digit = (c >= slfp_pkg::CH_ZERO) && (c <= slfp_pkg::CH_NINE);
  assign is_blank = (c == slfp_pkg::CH_SP) || (c == slfp_pkg::CH_TAB) ||
                    (c == slfp_pkg::CH_VT) || (c == slfp_pkg::CH_FF);
  assign dig      = c[3:0];

  assign produce  = s1_vld_r && (c == slfp_pkg::CH_LF) && (len_r != '0);
  assign out_free = !out_vld_r || out_tready;
  assign s1_fire  = s1_vld_r && (!produce || out_free);
  assign in_tready = !s1_vld_r || s1_fire;

  assign flow_f = seen_r[slfp_pkg::SLOT_F];
  assign ok     = seen_r[slfp_pkg::SLOT_O2] && seen_r[slfp_pkg::SLOT_T] &&
                  (flow_f || seen_r[slfp_pkg::SLOT_P]);

  assign s1_vld_nxt = (in_tvalid && in_tready) || (s1_vld_r && !s1_fire);

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_ok_nxt   = out_ok_r;
    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (s1_fire && produce) begin
      out_vld_nxt = 1'b1;
      out_ok_nxt  = ok;
      if (ok) begin
        out_data_nxt[VW-1:0] = slfp_pkg::to_signed(mag_r[slfp_pkg::SLOT_O2],
                                                   neg_r[slfp_pkg::SLOT_O2]);
        out_data_nxt[2*VW-1:VW] = flow_f ?
          slfp_pkg::to_signed(mag_r[slfp_pkg::SLOT_F], neg_r[slfp_pkg::SLOT_F]) :
          slfp_pkg::to_signed(mag_r[slfp_pkg::SLOT_P], neg_r[slfp_pkg::SLOT_P]);
        out_data_nxt[3*VW-1:2*VW] = slfp_pkg::to_signed(mag_r[slfp_pkg::SLOT_T],
                                                        neg_r[slfp_pkg::SLOT_T]);
      end else begin
        out_data_nxt = '0;
      end
    end
  end

  always_comb begin
    logic clear;
    logic [NS-1:0] start;
    clear    = 1'b0;
    start    = '0;
    len_nxt  = len_r;
    prev_nxt = prev_r;
    seen_nxt = seen_r;
    neg_nxt  = neg_r;
    for (int i = 0; i < NS; i++) begin
      phase_nxt[i] = phase_r[i];
      mag_nxt[i]   = mag_r[i];
      frac_nxt[i]  = frac_r[i];
    end
    if (s1_fire && (c != slfp_pkg::CH_CR)) begin
      if ((c == slfp_pkg::CH_LF) || (len_r == slfp_pkg::LINE_FULL)) begin
        clear = 1'b1;
      end else begin
        for (int i = 0; i < NS; i++) begin
          case (phase_r[i])
            slfp_pkg::PH_BLANK, slfp_pkg::PH_SIGN, slfp_pkg::PH_INT: begin
              if ((phase_r[i] == slfp_pkg::PH_BLANK) && is_blank) begin
                phase_nxt[i] = phase_r[i];
              end else if ((phase_r[i] == slfp_pkg::PH_BLANK) &&
                           ((c == slfp_pkg::CH_PLUS) || (c == slfp_pkg::CH_MINUS))) begin
                neg_nxt[i]   = (c == slfp_pkg::CH_MINUS);
                phase_nxt[i] = slfp_pkg::PH_SIGN;
              end else if (is_digit) begin
                mag_nxt[i]   = slfp_pkg::sat_step(mag_r[i], 1'b1, 10'(dig) * 10'd100);
                phase_nxt[i] = slfp_pkg::PH_INT;
              end else if (c == slfp_pkg::CH_DOT) begin
                phase_nxt[i] = slfp_pkg::PH_FRAC;
              end else begin
                phase_nxt[i] = slfp_pkg::PH_DONE;
              end
            end
            slfp_pkg::PH_FRAC: begin
              if (!is_digit) begin
                phase_nxt[i] = slfp_pkg::PH_DONE;
              end else if (frac_r[i] == 2'd0) begin
                mag_nxt[i]  = slfp_pkg::sat_step(mag_r[i], 1'b0, 10'(dig) * 10'd10);
                frac_nxt[i] = 2'd1;
              end else if (frac_r[i] == 2'd1) begin
                mag_nxt[i]  = slfp_pkg::sat_step(mag_r[i], 1'b0, 10'(dig));
                frac_nxt[i] = 2'd2;
              end
            end
            default: begin
              phase_nxt[i] = phase_r[i];
            end
          endcase
        end
        if (c == slfp_pkg::CH_COLON) begin
          start[slfp_pkg::SLOT_O2] = (prev_r[15:8] == slfp_pkg::CH_O) &&
                                     (prev_r[7:0] == slfp_pkg::CH_TWO);
          start[slfp_pkg::SLOT_F]  = (prev_r[7:0] == slfp_pkg::CH_F);
          start[slfp_pkg::SLOT_P]  = (prev_r[7:0] == slfp_pkg::CH_P);
          start[slfp_pkg::SLOT_T]  = (prev_r[7:0] == slfp_pkg::CH_T);
        end
        for (int i = 0; i < NS; i++) begin
          if (start[i] && !seen_r[i]) begin
            seen_nxt[i]  = 1'b1;
            phase_nxt[i] = slfp_pkg::PH_BLANK;
            neg_nxt[i]   = 1'b0;
            mag_nxt[i]   = '0;
            frac_nxt[i]  = 2'd0;
          end
        end
        prev_nxt = {prev_r[7:0], c};
        len_nxt  = len_r + LW'(1);
      end
    end
    if (clear) begin
      len_nxt  = '0;
      prev_nxt = '0;
      seen_nxt = '0;
      neg_nxt  = '0;
      for (int i = 0; i < NS; i++) begin
        phase_nxt[i] = slfp_pkg::PH_IDLE;
        mag_nxt[i]   = '0;
        frac_nxt[i]  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      len_r     <= '0;
      prev_r    <= '0;
      seen_r    <= '0;
      neg_r     <= '0;
      for (int i = 0; i < NS; i++) begin
        phase_r[i] <= slfp_pkg::PH_IDLE;
        mag_r[i]   <= '0;
        frac_r[i]  <= 2'd0;
      end
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      len_r     <= len_nxt;
      prev_r    <= prev_nxt;
      seen_r    <= seen_nxt;
      neg_r     <= neg_nxt;
      for (int i = 0; i < NS; i++) begin
        phase_r[i] <= phase_nxt[i];
        mag_r[i]   <= mag_nxt[i];
        frac_r[i]  <= frac_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

endmodule

>>> src/slfp_checker.sv
// ----------------------------------------------------------------------------
// slfp_checker
// Port-level checks of the sensor line field parser, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);

  `SLFP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "out stalled beat changed")
  `SLFP_ASSERT(a_fail_zero, out_tvalid && !out_tuser |-> out_tdata == 72'd0, "failed line carries nonzero values")
  `SLFP_ASSERT(a_saturated, out_tvalid |-> out_tdata[23:0] != 24'h800000 && out_tdata[47:24] != 24'h800000 && out_tdata[71:48] != 24'h800000, "value beyond saturation range")
  `SLFP_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input stalled with empty result register")
  `SLFP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

bind sensor_line_field_parser slfp_checker u_slfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
